FILE: design/sshbf_pkg.sv
// Package: shared types, constants and state encoding for the SSH brute-force detector.
package sshbf_pkg;

    localparam int SOURCE_SLOTS_DEF = 64;
    localparam int RING_DEPTH_DEF   = 16;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SERVICE_PORT   = 2'd0,
        REG_WINDOW_LEN     = 2'd1,
        REG_THRESHOLD      = 2'd2,
        REG_SEVERITY       = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic        is_tcp;
        logic [15:0] destination_port;
        logic [31:0] source_address;
        logic [31:0] destination_address;
        logic [39:0] event_time;
        logic [30:0] next_alert_id;
    } t_event;

    typedef struct packed {
        logic [30:0] alert_id;
        logic [39:0] alert_time;
        logic [31:0] offending_source;
        logic [31:0] target_address;
        logic        multiple_targets;
        logic [4:0]  attempt_total;
        logic [2:0]  severity_code;
    } t_alert;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SLOT_RD,
        ST_SLOT_CHK,
        ST_APPEND,
        ST_PRUNE_RD,
        ST_PRUNE_CHK,
        ST_SLOT_WR,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_EMIT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load_event;
        logic slot_rd;
        logic slot_chk;
        logic append;
        logic prune_rd;
        logic prune_step;
        logic slot_wr;
        logic scan_start;
        logic scan_rd;
        logic scan_step;
        logic out_load;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic counted;
        logic prune_hit;
        logic count_zero;
        logic alert;
        logic scan_done;
    } t_status;

endpackage

FILE: design/sshbf_if.sv
// Interfaces: valid/ready stream channel and configuration write channel.
interface sshbf_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sshbf_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [sshbf_pkg::CFG_IDX_W-1:0]  index;
    logic [sshbf_pkg::CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: design/sshbf_ctrl.sv
// Controller: sequences slot lookup, append, pruning, destination scan and alert output.
module sshbf_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_out_busy,
    input  sshbf_pkg::t_status  i_status,
    output sshbf_pkg::t_cmd     o_cmd
);

    sshbf_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sshbf_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            sshbf_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = sshbf_pkg::ST_SLOT_RD;
            end
            sshbf_pkg::ST_SLOT_RD: begin
                n_state = i_status.counted ? sshbf_pkg::ST_SLOT_CHK : sshbf_pkg::ST_IDLE;
            end
            sshbf_pkg::ST_SLOT_CHK:  n_state = sshbf_pkg::ST_APPEND;
            sshbf_pkg::ST_APPEND:    n_state = sshbf_pkg::ST_PRUNE_RD;
            sshbf_pkg::ST_PRUNE_RD:  n_state = sshbf_pkg::ST_PRUNE_CHK;
            sshbf_pkg::ST_PRUNE_CHK: begin
                if (i_status.prune_hit && !i_status.count_zero) begin
                    n_state = sshbf_pkg::ST_PRUNE_RD;
                end else begin
                    n_state = sshbf_pkg::ST_SLOT_WR;
                end
            end
            sshbf_pkg::ST_SLOT_WR: begin
                n_state = i_status.alert ? sshbf_pkg::ST_SCAN_RD : sshbf_pkg::ST_IDLE;
            end
            sshbf_pkg::ST_SCAN_RD:  n_state = sshbf_pkg::ST_SCAN_CHK;
            sshbf_pkg::ST_SCAN_CHK: begin
                n_state = i_status.scan_done ? sshbf_pkg::ST_EMIT : sshbf_pkg::ST_SCAN_RD;
            end
            sshbf_pkg::ST_EMIT: begin
                if (!i_out_busy) n_state = sshbf_pkg::ST_IDLE;
            end
            default: n_state = sshbf_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            sshbf_pkg::ST_IDLE: begin
                o_in_ready      = 1'b1;
                o_cmd.load_event = i_in_valid;
            end
            sshbf_pkg::ST_SLOT_RD:   o_cmd.slot_rd    = 1'b1;
            sshbf_pkg::ST_SLOT_CHK:  o_cmd.slot_chk   = 1'b1;
            sshbf_pkg::ST_APPEND:    o_cmd.append     = 1'b1;
            sshbf_pkg::ST_PRUNE_RD:  o_cmd.prune_rd   = 1'b1;
            sshbf_pkg::ST_PRUNE_CHK: o_cmd.prune_step = 1'b1;
            sshbf_pkg::ST_SLOT_WR: begin
                o_cmd.slot_wr    = 1'b1;
                o_cmd.scan_start = 1'b1;
            end
            sshbf_pkg::ST_SCAN_RD:  o_cmd.scan_rd   = 1'b1;
            sshbf_pkg::ST_SCAN_CHK: o_cmd.scan_step = 1'b1;
            sshbf_pkg::ST_EMIT:     o_cmd.out_load  = !i_out_busy;
            default: ;
        endcase
    end

endmodule

FILE: design/sshbf_dp.sv
// Datapath: slot table, ring memories, prune and scan registers, output register.
module sshbf_dp #(
    parameter int SOURCE_SLOTS = sshbf_pkg::SOURCE_SLOTS_DEF,
    parameter int RING_DEPTH   = sshbf_pkg::RING_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sshbf_pkg::t_event   i_event,
    input  sshbf_pkg::t_cmd     i_cmd,
    output sshbf_pkg::t_status  o_status,
    input  logic [15:0]         i_service_port,
    input  logic [31:0]         i_window_len,
    input  logic [4:0]          i_threshold,
    input  logic [2:0]          i_severity,
    output logic                o_out_busy,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output sshbf_pkg::t_alert   o_out_data
);

    localparam int SW  = (SOURCE_SLOTS > 1) ? $clog2(SOURCE_SLOTS) : 1;
    localparam int HW  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CW  = $clog2(RING_DEPTH + 1);
    localparam int AW  = (CW > 5) ? CW : 5;
    localparam int RAW = SW + HW;
    localparam logic [CW-1:0] DEPTH_C = CW'(RING_DEPTH);

    logic [SOURCE_SLOTS-1:0] r_valid;
    logic [31:0]   m_src   [SOURCE_SLOTS];
    logic [CW-1:0] m_cnt   [SOURCE_SLOTS];
    logic [HW-1:0] m_head  [SOURCE_SLOTS];
    logic [39:0]   m_time  [SOURCE_SLOTS*RING_DEPTH];
    logic [31:0]   m_tgt   [SOURCE_SLOTS*RING_DEPTH];

    sshbf_pkg::t_event r_ev;
    logic [SW-1:0] w_slot;
    logic [31:0]   r_rd_src;
    logic          r_rd_valid;
    logic [CW-1:0] r_rd_cnt, r_cnt;
    logic [HW-1:0] r_rd_head, r_head, r_k;
    logic [39:0]   r_rd_time;
    logic [31:0]   r_rd_tgt, r_first;
    logic          r_multi, r_first_ok;
    logic [CW-1:0] r_scan_n;
    logic          r_out_valid;
    sshbf_pkg::t_alert r_out;

    logic [HW-1:0] w_tail, w_ptr;
    logic [RAW-1:0] w_addr;
    logic [39:0]   w_diff;

    if (SOURCE_SLOTS > 1) begin : g_slot
        assign w_slot = r_ev.source_address[SW-1:0];
    end else begin : g_slot1
        assign w_slot = 1'b0;
    end

    function automatic logic [HW-1:0] wrap(input logic [HW:0] v);
        logic [HW:0] d;
        d = v - (HW+1)'(RING_DEPTH);
        return (v >= (HW+1)'(RING_DEPTH)) ? d[HW-1:0] : v[HW-1:0];
    endfunction

    // count is below ring depth at append time
    assign w_tail = wrap({1'b0, r_head} + (HW+1)'(r_cnt));
    always_comb begin
        w_ptr = r_head;
        if (i_cmd.scan_rd) w_ptr = r_k;
        if (i_cmd.append)  w_ptr = w_tail;
    end
    if (RING_DEPTH > 1) begin : g_addr
        assign w_addr = {w_slot, w_ptr};
    end else begin : g_addr1
        assign w_addr = {w_slot, 1'b0};
    end

    assign w_diff = r_ev.event_time - r_rd_time;

    assign o_status.counted    = r_ev.is_tcp && (r_ev.destination_port == i_service_port);
    assign o_status.prune_hit  = (r_ev.event_time > r_rd_time) &&
                                 (w_diff > {8'd0, i_window_len});
    assign o_status.count_zero = (r_cnt == CW'(1));
    assign o_status.alert      = (AW'(r_cnt) >= AW'(i_threshold));
    assign o_status.scan_done  = (r_scan_n <= CW'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (i_cmd.slot_wr) r_valid[w_slot] <= !o_status.alert;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_event) r_ev <= i_event;
        if (i_cmd.slot_rd) begin
            r_rd_src   <= m_src[w_slot];
            r_rd_cnt   <= m_cnt[w_slot];
            r_rd_head  <= m_head[w_slot];
            r_rd_valid <= r_valid[w_slot];
        end
        if (i_cmd.slot_chk) begin
            if (!r_rd_valid || r_rd_src != r_ev.source_address) begin
                r_head <= '0;
                r_cnt  <= '0;
            end else if (r_rd_cnt >= DEPTH_C) begin
                r_head <= wrap({1'b0, r_rd_head} + (HW+1)'(1));
                r_cnt  <= DEPTH_C - CW'(1);
            end else begin
                r_head <= r_rd_head;
                r_cnt  <= r_rd_cnt;
            end
        end
        if (i_cmd.append) begin
            m_time[w_addr] <= r_ev.event_time;
            m_tgt[w_addr]  <= r_ev.destination_address;
            r_cnt          <= r_cnt + CW'(1);
        end
        if (i_cmd.prune_rd || i_cmd.scan_rd) begin
            r_rd_time <= m_time[w_addr];
            r_rd_tgt  <= m_tgt[w_addr];
        end
        if (i_cmd.prune_step && o_status.prune_hit) begin
            r_head <= wrap({1'b0, r_head} + (HW+1)'(1));
            r_cnt  <= r_cnt - CW'(1);
        end
        if (i_cmd.slot_wr) begin
            m_src[w_slot]  <= r_ev.source_address;
            m_cnt[w_slot]  <= r_cnt;
            m_head[w_slot] <= r_head;
        end
        if (i_cmd.scan_start) begin
            r_k        <= r_head;
            r_scan_n   <= r_cnt;
            r_multi    <= 1'b0;
            r_first_ok <= 1'b0;
        end
        if (i_cmd.scan_step) begin
            r_k        <= wrap({1'b0, r_k} + (HW+1)'(1));
            r_scan_n   <= r_scan_n - CW'(1);
            r_first_ok <= 1'b1;
            if (!r_first_ok) r_first <= r_rd_tgt;
            else if (r_rd_tgt != r_first) r_multi <= 1'b1;
        end
        if (i_cmd.out_load) begin
            r_out.alert_id         <= r_ev.next_alert_id;
            r_out.alert_time       <= r_ev.event_time;
            r_out.offending_source <= r_ev.source_address;
            r_out.target_address   <= r_multi ? 32'd0 : r_first;
            r_out.multiple_targets <= r_multi;
            r_out.attempt_total    <= 5'(r_cnt);
            r_out.severity_code    <= i_severity;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_busy  = r_out_valid && !i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: design/ssh_brute_force_window_detector.sv
// Top level: SSH brute-force sliding-window detector with config registers.
// One event is handled at a time. An ignored event returns to idle after the slot read;
// a counted event runs slot check, append, pruning (at most RING_DEPTH - 1 attempts) and
// slot write; one that alerts adds a scan of the attempts in window, each pruning and
// scan step reading the single-port ring memory once. The alert sits in an output register,
// so the block returns to idle once the previous alert is taken. Slot valid bits clear at reset.
module ssh_brute_force_window_detector #(
    parameter int SOURCE_SLOTS = sshbf_pkg::SOURCE_SLOTS_DEF,
    parameter int RING_DEPTH   = sshbf_pkg::RING_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    sshbf_stream_if.sink   in_ch,
    sshbf_stream_if.source out_ch,
    sshbf_cfg_if.sink      cfg_ch
);

    logic [15:0] r_port;
    logic [31:0] r_window;
    logic [4:0]  r_thr;
    logic [2:0]  r_sev;

    sshbf_pkg::t_cmd    w_cmd;
    sshbf_pkg::t_status w_status;
    logic               w_out_busy;

    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_port   <= 16'd22;
            r_window <= 32'd60;
            r_thr    <= 5'd5;
            r_sev    <= 3'd2;
        end else if (cfg_ch.valid) begin
            case (sshbf_pkg::t_reg_idx'(cfg_ch.index))
                sshbf_pkg::REG_SERVICE_PORT:   r_port   <= cfg_ch.data[15:0];
                sshbf_pkg::REG_WINDOW_LEN:     r_window <= cfg_ch.data;
                sshbf_pkg::REG_THRESHOLD:      r_thr    <= cfg_ch.data[4:0];
                sshbf_pkg::REG_SEVERITY:       r_sev    <= cfg_ch.data[2:0];
                default: ;
            endcase
        end
    end

    sshbf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_ch.valid),
        .o_in_ready (in_ch.ready),
        .i_out_busy (w_out_busy),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    sshbf_dp #(
        .SOURCE_SLOTS (SOURCE_SLOTS),
        .RING_DEPTH   (RING_DEPTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_event          (in_ch.data),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .i_service_port   (r_port),
        .i_window_len     (r_window),
        .i_threshold      (r_thr),
        .i_severity       (r_sev),
        .o_out_busy       (w_out_busy),
        .o_out_valid      (out_ch.valid),
        .i_out_ready      (out_ch.ready),
        .o_out_data       (out_ch.data)
    );

endmodule
